// File: rtl/rzbp_pkg.sv
package rzbp_pkg;

  localparam int ZONE_TOTAL_DEF = 676;
  localparam int QUEUE_DEPTH    = 4;
  localparam int DESC_BITS      = 26;

  localparam logic [2:0] HEADER_BYTES = 3'd6;
  localparam logic [7:0] XLO_BIAS     = 8'd128;

  localparam logic       KIND_ZONE    = 1'b0;
  localparam logic       KIND_SUMMARY = 1'b1;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_SHORT = 2'd1;
  localparam logic [1:0] STATUS_TRUNC = 2'd2;

  // byte class assigned by the front end
  typedef enum logic [2:0] {
    TAG_SKIP = 3'd0,
    TAG_XHI  = 3'd1,
    TAG_XLO  = 3'd2,
    TAG_ZHI  = 3'd3,
    TAG_ZLO  = 3'd4,
    TAG_BODY = 3'd5
  } tag_t;

  typedef struct packed {
    tag_t       tag;
    logic [7:0] data;
    logic       last;
  } qword_t;

  typedef struct packed {
    logic        kind;
    logic [9:0]  zone_index;
    logic        present;
    logic [1:0]  rotation;
    logic [10:0] src_z;
    logic [9:0]  src_x;
    logic [1:0]  src_level;
    logic [15:0] base_x;
    logic [15:0] base_z;
    logic [9:0]  present_count;
    logic [15:0] key_total;
    logic [1:0]  status;
  } rec_t;

endpackage

// File: rtl/rzbp_front.sv
module rzbp_front
  import rzbp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] byte_in,
  input  logic       is_last,
  output logic       push_valid,
  output qword_t     push_word,
  input  logic       push_ready
);

  logic [2:0] pos;
  tag_t       tag;

  assign in_ready   = push_ready;
  assign push_valid = in_valid;

  always_comb begin
    case (pos)
      3'd2:    tag = TAG_XHI;
      3'd3:    tag = TAG_XLO;
      3'd4:    tag = TAG_ZHI;
      3'd5:    tag = TAG_ZLO;
      3'd0,
      3'd1:    tag = TAG_SKIP;
      default: tag = TAG_BODY;
    endcase
  end

  assign push_word.tag  = tag;
  assign push_word.data = byte_in;
  assign push_word.last = is_last;

  // position within the packet, saturates once past the header
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= 3'd0;
    end else if (in_valid && push_ready) begin
      if (is_last) begin
        pos <= 3'd0;
      end else if (pos != HEADER_BYTES) begin
        pos <= pos + 3'd1;
      end
    end
  end

endmodule

// File: rtl/rzbp_queue.sv
module rzbp_queue
  import rzbp_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push_valid,
  output logic   push_ready,
  input  qword_t push_word,
  output logic   pop_valid,
  input  logic   pop_ready,
  output qword_t pop_word
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam logic [PW:0] FULL = (PW + 1)'(QUEUE_DEPTH);

  qword_t        mem [QUEUE_DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [PW:0]   count;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (count != FULL);
  assign pop_valid  = (count != '0);
  assign pop_word   = mem[rptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= wptr + PW'(1);
      end
      if (do_pop) begin
        rptr <= rptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + (PW + 1)'(1);
      end else if (do_pop && !do_push) begin
        count <= count - (PW + 1)'(1);
      end
    end
  end

endmodule

// File: rtl/rzbp_back.sv
module rzbp_back
  import rzbp_pkg::*;
#(
  parameter int ZONE_TOTAL = ZONE_TOTAL_DEF
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   pop_valid,
  output logic   pop_ready,
  input  qword_t pop_word,
  output logic   out_valid,
  input  logic   out_ready,
  output rec_t   out_rec
);

  localparam logic [10:0] ZT        = 11'(ZONE_TOTAL);
  localparam logic [4:0]  DESC_LAST = 5'(DESC_BITS - 1);

  typedef enum logic [2:0] {
    W_IDLE = 3'b001,
    W_BITS = 3'b010,
    W_SUM  = 3'b100
  } work_t;

  typedef enum logic [4:0] {
    P_HEAD  = 5'b00001,
    P_FLAG  = 5'b00010,
    P_DESC  = 5'b00100,
    P_COUNT = 5'b01000,
    P_KEYS  = 5'b10000
  } phase_t;

  work_t       work, work_next;
  phase_t      phase, phase_next;
  logic [15:0] hdr_x, hdr_x_next;
  logic [15:0] hdr_z, hdr_z_next;
  logic [25:0] acc, acc_next;
  logic [4:0]  taken, taken_next;
  logic [9:0]  zone, zone_next;
  logic [9:0]  ptotal, ptotal_next;
  logic [15:0] cword, cword_next;
  logic [1:0]  cbt, cbt_next;
  logic [7:0]  shreg, shreg_next;
  logic [2:0]  bitn, bitn_next;
  logic        last_r, last_next;
  logic        out_valid_next;
  rec_t        out_rec_next;

  logic        slot_free;
  logic        emit;
  rec_t        rec;
  logic        cur_bit;
  logic [25:0] acc_sh;
  logic [10:0] zone_inc;
  logic        zones_done;
  logic        need_rec;
  logic        end_byte;
  logic        go_bits;

  assign slot_free  = !out_valid || out_ready;
  assign cur_bit    = shreg[7];
  assign acc_sh     = {acc[24:0], cur_bit};
  assign zone_inc   = {1'b0, zone} + 11'd1;
  assign zones_done = (zone_inc >= ZT);

  always_comb begin
    work_next   = work;
    phase_next  = phase;
    hdr_x_next  = hdr_x;
    hdr_z_next  = hdr_z;
    acc_next    = acc;
    taken_next  = taken;
    zone_next   = zone;
    ptotal_next = ptotal;
    cword_next  = cword;
    cbt_next    = cbt;
    shreg_next  = shreg;
    bitn_next   = bitn;
    last_next   = last_r;
    pop_ready   = 1'b0;
    emit        = 1'b0;
    rec         = '0;
    need_rec    = 1'b0;
    end_byte    = 1'b0;
    go_bits     = 1'b0;

    case (work)
      W_IDLE: begin
        if (pop_valid) begin
          pop_ready = 1'b1;
          last_next = pop_word.last;
          case (pop_word.tag)
            TAG_XHI: hdr_x_next = {pop_word.data, 8'h00};
            TAG_XLO: hdr_x_next[7:0] = pop_word.data - XLO_BIAS;
            TAG_ZHI: hdr_z_next = {pop_word.data, 8'h00};
            TAG_ZLO: begin
              hdr_z_next[7:0] = pop_word.data;
              phase_next      = P_FLAG;
            end
            TAG_BODY: begin
              case (phase)
                P_FLAG, P_DESC: begin
                  go_bits    = 1'b1;
                  shreg_next = pop_word.data;
                  bitn_next  = 3'd0;
                  work_next  = W_BITS;
                end
                P_COUNT: begin
                  cword_next = {cword[7:0], pop_word.data};
                  cbt_next   = cbt + 2'd1;
                  if (cbt == 2'd1) begin
                    phase_next = P_KEYS;
                  end
                end
                default: ;
              endcase
            end
            default: ;
          endcase
          if (pop_word.last && !go_bits) begin
            work_next = W_SUM;
          end
        end
      end

      W_BITS: begin
        need_rec = (phase == P_FLAG && !cur_bit) ||
                   (phase == P_DESC && taken == DESC_LAST);
        if (!need_rec || slot_free) begin
          shreg_next = {shreg[6:0], 1'b0};
          bitn_next  = bitn + 3'd1;
          end_byte   = (bitn == 3'd7);
          case (phase)
            P_FLAG: begin
              if (cur_bit) begin
                phase_next = P_DESC;
                acc_next   = '0;
                taken_next = '0;
              end else begin
                emit           = 1'b1;
                rec.kind       = KIND_ZONE;
                rec.zone_index = zone;
                zone_next      = zone_inc[9:0];
                phase_next     = zones_done ? P_COUNT : P_FLAG;
                if (zones_done) begin
                  end_byte = 1'b1;
                end
              end
            end
            P_DESC: begin
              acc_next   = acc_sh;
              taken_next = taken + 5'd1;
              if (taken == DESC_LAST) begin
                emit           = 1'b1;
                rec.kind       = KIND_ZONE;
                rec.zone_index = zone;
                rec.present    = 1'b1;
                rec.rotation   = acc_sh[2:1];
                rec.src_z      = acc_sh[13:3];
                rec.src_x      = acc_sh[23:14];
                rec.src_level  = acc_sh[25:24];
                ptotal_next    = ptotal + 10'd1;
                acc_next       = '0;
                taken_next     = '0;
                zone_next      = zone_inc[9:0];
                phase_next     = zones_done ? P_COUNT : P_FLAG;
                if (zones_done) begin
                  end_byte = 1'b1;
                end
              end
            end
            default: ;
          endcase
          if (end_byte) begin
            work_next = last_r ? W_SUM : W_IDLE;
          end
        end
      end

      W_SUM: begin
        if (slot_free) begin
          emit     = 1'b1;
          rec.kind = KIND_SUMMARY;
          if (phase == P_HEAD) begin
            rec.status = STATUS_SHORT;
          end else begin
            rec.base_x        = hdr_x;
            rec.base_z        = hdr_z;
            rec.present_count = ptotal;
            if (phase == P_FLAG || phase == P_DESC) begin
              rec.status = STATUS_TRUNC;
            end else begin
              rec.status = STATUS_OK;
              if (cbt == 2'd2) begin
                rec.key_total = cword;
              end
            end
          end
          // back to the start-of-packet state
          phase_next  = P_HEAD;
          hdr_x_next  = '0;
          hdr_z_next  = '0;
          acc_next    = '0;
          taken_next  = '0;
          zone_next   = '0;
          ptotal_next = '0;
          cword_next  = '0;
          cbt_next    = '0;
          work_next   = W_IDLE;
        end
      end

      default: work_next = W_IDLE;
    endcase

    if (emit) begin
      out_valid_next = 1'b1;
      out_rec_next   = rec;
    end else begin
      out_valid_next = out_valid && !out_ready;
      out_rec_next   = out_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      work      <= W_IDLE;
      phase     <= P_HEAD;
      hdr_x     <= '0;
      hdr_z     <= '0;
      acc       <= '0;
      taken     <= '0;
      zone      <= '0;
      ptotal    <= '0;
      cword     <= '0;
      cbt       <= '0;
      out_valid <= 1'b0;
    end else begin
      work      <= work_next;
      phase     <= phase_next;
      hdr_x     <= hdr_x_next;
      hdr_z     <= hdr_z_next;
      acc       <= acc_next;
      taken     <= taken_next;
      zone      <= zone_next;
      ptotal    <= ptotal_next;
      cword     <= cword_next;
      cbt       <= cbt_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    shreg   <= shreg_next;
    bitn    <= bitn_next;
    last_r  <= last_next;
    out_rec <= out_rec_next;
  end

endmodule

// File: rtl/region_zone_bitfield_parser_unit.sv
// Channel  Handshake            Word
// input    in_valid / in_ready  byte_in, is_last
// output   out_valid / out_ready  record_kind .. status (12 fields)
//
// Header, count and key bytes are taken in the idle state; a bit-section byte is
// loaded there, then decoded one bit per cycle by the serial bit decoder unless a
// record step stalls. A packet's summary record follows its last byte.
// A four-word queue lets the input keep accepting while the decoder works.
// rst is synchronous; it empties the queue and returns the parser to the header.
// A bit step that produces a record waits while the output register is full.
module region_zone_bitfield_parser_unit
  import rzbp_pkg::*;
#(
  parameter int ZONE_TOTAL = ZONE_TOTAL_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  byte_in,
  input  logic        is_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        record_kind,
  output logic [9:0]  zone_index,
  output logic        zone_present,
  output logic [1:0]  rotation,
  output logic [10:0] source_zone_z,
  output logic [9:0]  source_zone_x,
  output logic [1:0]  source_level,
  output logic [15:0] base_zone_x,
  output logic [15:0] base_zone_z,
  output logic [9:0]  present_count,
  output logic [15:0] key_total,
  output logic [1:0]  status
);

  logic   push_valid;
  logic   push_ready;
  qword_t push_word;
  logic   pop_valid;
  logic   pop_ready;
  qword_t pop_word;
  rec_t   rec;

  rzbp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .byte_in    (byte_in),
    .is_last    (is_last),
    .push_valid (push_valid),
    .push_word  (push_word),
    .push_ready (push_ready)
  );

  rzbp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_word  (push_word),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_word   (pop_word)
  );

  rzbp_back #(
    .ZONE_TOTAL (ZONE_TOTAL)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_word  (pop_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_rec   (rec)
  );

  assign record_kind   = rec.kind;
  assign zone_index    = rec.zone_index;
  assign zone_present  = rec.present;
  assign rotation      = rec.rotation;
  assign source_zone_z = rec.src_z;
  assign source_zone_x = rec.src_x;
  assign source_level  = rec.src_level;
  assign base_zone_x   = rec.base_x;
  assign base_zone_z   = rec.base_z;
  assign present_count = rec.present_count;
  assign key_total     = rec.key_total;
  assign status        = rec.status;

endmodule

// File: tb/region_zone_bitfield_parser_unit_tb.sv
`timescale 1ns / 100ps

module region_zone_bitfield_parser_unit_tb
  import rzbp_pkg::*;
();

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_WORDS   = 330;
  localparam int DRAIN_CYCLES   = 50;
  localparam int MAX_PRINTED    = 100;

  typedef enum logic [2:0] {
    PARSE_HEADER,
    PARSE_FLAG,
    PARSE_DESC,
    PARSE_COUNT,
    PARSE_KEYS
  } parse_phase_t;

  typedef enum logic [1:0] {
    TAIL_NONE,
    TAIL_HALF_COUNT,
    TAIL_COUNT,
    TAIL_KEYS
  } tail_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  byte_in;
  logic        is_last;
  logic        out_valid;
  logic        out_ready;
  logic        record_kind;
  logic [9:0]  zone_index;
  logic        zone_present;
  logic [1:0]  rotation;
  logic [10:0] source_zone_z;
  logic [9:0]  source_zone_x;
  logic [1:0]  source_level;
  logic [15:0] base_zone_x;
  logic [15:0] base_zone_z;
  logic [9:0]  present_count;
  logic [15:0] key_total;
  logic [1:0]  status;

  region_zone_bitfield_parser_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .byte_in       (byte_in),
    .is_last       (is_last),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .record_kind   (record_kind),
    .zone_index    (zone_index),
    .zone_present  (zone_present),
    .rotation      (rotation),
    .source_zone_z (source_zone_z),
    .source_zone_x (source_zone_x),
    .source_level  (source_level),
    .base_zone_x   (base_zone_x),
    .base_zone_z   (base_zone_z),
    .present_count (present_count),
    .key_total     (key_total),
    .status        (status)
  );

  always #5 clk = ~clk;

  // parser shadow state
  parse_phase_t pr_phase;
  logic [15:0]  pr_pos;
  logic [15:0]  pr_base_x;
  logic [15:0]  pr_base_z;
  logic [25:0]  pr_desc;
  logic [4:0]   pr_desc_bits;
  logic [9:0]   pr_zone;
  logic [9:0]   pr_present;
  logic [15:0]  pr_keys;
  logic [1:0]   pr_key_bytes;

  rec_t        expected_recs[$];
  logic [7:0]  pkt_bytes[$];
  bit          zone_bits[$];

  int err_count    = 0;
  int words_sent   = 0;
  int stall_cycles = 0;
  int rx_hold      = 0;
  bit tx_idle_on   = 1'b0;
  bit rx_idle_on   = 1'b0;

  task automatic report_mismatch(input string what);
    err_count++;
    if (err_count <= MAX_PRINTED)
      $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic clear_parse_state();
    pr_phase     = PARSE_HEADER;
    pr_pos       = '0;
    pr_base_x    = '0;
    pr_base_z    = '0;
    pr_desc      = '0;
    pr_desc_bits = '0;
    pr_zone      = '0;
    pr_present   = '0;
    pr_keys      = '0;
    pr_key_bytes = '0;
  endtask

  task automatic push_zone(input logic present, input logic [25:0] d);
    rec_t r;
    r = '0;
    r.kind       = KIND_ZONE;
    r.zone_index = pr_zone;
    if (present) begin
      r.present   = 1'b1;
      r.rotation  = d[2:1];     // bit 0 unused
      r.src_z     = d[13:3];
      r.src_x     = d[23:14];
      r.src_level = d[25:24];
    end
    expected_recs.push_back(r);
    pr_zone  = pr_zone + 10'd1;
    pr_phase = (pr_zone >= 10'(ZONE_TOTAL_DEF)) ? PARSE_COUNT : PARSE_FLAG;
  endtask

  task automatic predict_word(input logic [7:0] b, input logic last);
    rec_t r;
    logic bit_v;
    int   i;
    case (pr_phase)
      PARSE_HEADER: begin
        case (pr_pos)
          16'd2: pr_base_x = {b, 8'h00};
          16'd3: pr_base_x[7:0] = b - XLO_BIAS;
          16'd4: pr_base_z = {b, 8'h00};
          16'd5: pr_base_z[7:0] = b;
          default: ;
        endcase
        if (pr_pos != 16'hFFFF) pr_pos = pr_pos + 16'd1;
        if (pr_pos >= 16'(HEADER_BYTES)) pr_phase = PARSE_FLAG;
      end
      PARSE_FLAG, PARSE_DESC: begin
        // MSB first; bits after the last zone are dropped
        for (i = 7; i >= 0; i--) begin
          bit_v = b[i];
          if (pr_phase == PARSE_FLAG) begin
            if (bit_v) begin
              pr_phase     = PARSE_DESC;
              pr_desc      = '0;
              pr_desc_bits = '0;
            end else begin
              push_zone(1'b0, '0);
            end
          end else if (pr_phase == PARSE_DESC) begin
            pr_desc      = {pr_desc[24:0], bit_v};
            pr_desc_bits = pr_desc_bits + 5'd1;
            if (pr_desc_bits == 5'(DESC_BITS)) begin
              pr_present = pr_present + 10'd1;
              push_zone(1'b1, pr_desc);
            end
          end
        end
      end
      PARSE_COUNT: begin
        pr_keys      = {pr_keys[7:0], b};
        pr_key_bytes = pr_key_bytes + 2'd1;
        if (pr_key_bytes >= 2'd2) pr_phase = PARSE_KEYS;
      end
      default: ;
    endcase

    if (last) begin
      r = '0;
      r.kind = KIND_SUMMARY;
      if (pr_phase == PARSE_HEADER) begin
        r.status = STATUS_SHORT;
      end else begin
        r.base_x        = pr_base_x;
        r.base_z        = pr_base_z;
        r.present_count = pr_present;
        if (pr_phase == PARSE_FLAG || pr_phase == PARSE_DESC)
          r.status = STATUS_TRUNC;
        else if (pr_key_bytes >= 2'd2)
          r.key_total = pr_keys;
      end
      expected_recs.push_back(r);
      clear_parse_state();
    end
  endtask

  // mostly short gaps, a few long ones
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_word(input logic [7:0] b, input logic last);
    int g;
    g = tx_idle_on ? idle_gap() : 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    byte_in  <= b;
    is_last  <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_word(b, last);
    words_sent++;
  endtask

  task automatic send_packet();
    int i;
    for (i = 0; i < pkt_bytes.size(); i++)
      send_word(pkt_bytes[i], i == pkt_bytes.size() - 1);
  endtask

  // density: chance in 256 that a zone carries a descriptor
  task automatic build_packet(input int density, input tail_t tail);
    logic [25:0] d;
    logic [7:0]  acc;
    logic [15:0] cnt;
    int z, k, pick;
    pkt_bytes.delete();
    zone_bits.delete();
    repeat (6) pkt_bytes.push_back(8'($urandom));
    for (z = 0; z < ZONE_TOTAL_DEF; z++) begin
      if ($urandom_range(0, 255) < density) begin
        zone_bits.push_back(1'b1);
        pick = $urandom_range(0, 7);
        d = (pick == 0) ? '1 : (pick == 1) ? '0 : 26'($urandom);
        for (k = 25; k >= 0; k--) zone_bits.push_back(d[k]);
      end else begin
        zone_bits.push_back(1'b0);
      end
    end
    // filler after the last zone, random since it is dropped
    while (zone_bits.size() % 8 != 0) zone_bits.push_back(1'($urandom));
    acc = '0;
    for (k = 0; k < zone_bits.size(); k++) begin
      acc = {acc[6:0], zone_bits[k]};
      if (k % 8 == 7) pkt_bytes.push_back(acc);
    end
    pick = $urandom_range(0, 5);
    cnt  = (pick == 0) ? 16'hFFFF : (pick == 1) ? 16'h0000 : 16'($urandom);
    if (tail != TAIL_NONE) pkt_bytes.push_back(cnt[15:8]);
    if (tail == TAIL_COUNT || tail == TAIL_KEYS) pkt_bytes.push_back(cnt[7:0]);
    if (tail == TAIL_KEYS)
      repeat ($urandom_range(1, 6)) pkt_bytes.push_back(8'($urandom));
  endtask

  task automatic test_short_packets();
    pkt_bytes = '{8'hFF};
    send_packet();
    pkt_bytes = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'hFF};
    send_packet();
  endtask

  task automatic test_header_extremes();
    // all-zero body byte: eight absent zones, then a truncated summary
    pkt_bytes = '{8'h00, 8'h00, 8'hFF, 8'h7F, 8'hFF, 8'hFF, 8'h00};
    send_packet();
  endtask

  task automatic test_descriptor_fields();
    // one all-ones descriptor, then a second one cut off
    pkt_bytes = '{8'h12, 8'h34, 8'h00, 8'h80, 8'h00, 8'h00,
                  8'hFF, 8'hFF, 8'hFF, 8'hF0};
    send_packet();
  endtask

  task automatic test_backpressure();
    tx_idle_on = 1'b0;
    rx_hold    = 400;
    build_packet(0, TAIL_COUNT);
    send_packet();
  endtask

  task automatic test_random_packets();
    int target, r, cut;
    target = words_sent + RANDOM_WORDS;
    while (words_sent < target) begin
      tx_idle_on = $urandom_range(0, 3) != 0;
      rx_idle_on = $urandom_range(0, 3) != 0;
      r = $urandom_range(0, 9);
      if (r < 6) begin
        case ($urandom_range(0, 3))
          0: build_packet(0, tail_t'($urandom_range(0, 3)));
          1: build_packet(4, tail_t'($urandom_range(0, 3)));
          2: build_packet(8, tail_t'($urandom_range(0, 3)));
          default: build_packet(16, tail_t'($urandom_range(0, 3)));
        endcase
      end else if (r < 8) begin
        build_packet(8, TAIL_NONE);
        cut = $urandom_range(6, pkt_bytes.size() - 1);
        while (pkt_bytes.size() > cut) void'(pkt_bytes.pop_back());
      end else if (r < 9) begin
        pkt_bytes.delete();
        repeat ($urandom_range(1, 5)) pkt_bytes.push_back(8'($urandom));
      end else begin
        pkt_bytes.delete();
        repeat ($urandom_range(1, 12)) pkt_bytes.push_back(8'($urandom));
      end
      send_packet();
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want, input logic [9:0] zone);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h want %0h (zone %0d)", name, got, want, zone));
  endtask

  always @(posedge clk) begin : rec_checker
    rec_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_recs.size() == 0) begin
        report_mismatch("record arrived with none expected");
      end else begin
        want = expected_recs.pop_front();
        check_field("record_kind", 16'(record_kind), 16'(want.kind), want.zone_index);
        check_field("zone_index", 16'(zone_index), 16'(want.zone_index), want.zone_index);
        check_field("zone_present", 16'(zone_present), 16'(want.present), want.zone_index);
        check_field("rotation", 16'(rotation), 16'(want.rotation), want.zone_index);
        check_field("source_zone_z", 16'(source_zone_z), 16'(want.src_z), want.zone_index);
        check_field("source_zone_x", 16'(source_zone_x), 16'(want.src_x), want.zone_index);
        check_field("source_level", 16'(source_level), 16'(want.src_level),
                    want.zone_index);
        check_field("base_zone_x", base_zone_x, want.base_x, want.zone_index);
        check_field("base_zone_z", base_zone_z, want.base_z, want.zone_index);
        check_field("present_count", 16'(present_count), 16'(want.present_count),
                    want.zone_index);
        check_field("key_total", key_total, want.key_total, want.zone_index);
        check_field("status", 16'(status), 16'(want.status), want.zone_index);
      end
    end
  end

  // output side pacing; a requested hold is counted here
  initial begin : rx_pacer
    int k;
    out_ready = 1'b0;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      if (rx_hold > 0) begin
        k       = rx_hold;
        rx_hold = 0;
        out_ready <= 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
        k = 1 + idle_gap();
        out_ready <= 1'b0;
      end else begin
        k = 1;
        out_ready <= 1'b1;
      end
      repeat (k) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("** region_zone_bitfield_parser_unit: FAILED **");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst      = 1'b1;
    in_valid = 1'b0;
    byte_in  = '0;
    is_last  = 1'b0;
    clear_parse_state();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_short_packets();
    test_header_extremes();
    test_descriptor_fields();
    test_backpressure();
    test_random_packets();

    in_valid   <= 1'b0;
    rx_idle_on = 1'b0;
    while (expected_recs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_count == 0) begin
      $display("** region_zone_bitfield_parser_unit: PASSED **");
    end else begin
      $display("** region_zone_bitfield_parser_unit: FAILED **");
    end
    $finish;
  end

endmodule
